FILE: rtl/integer_to_ascii_converter_macros.svh
// ----------------------------------------------------------------------------
// integer to ascii converter assertion macros
// shared concurrent assertion shorthands for the converter modules
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_CONVERTER_MACROS_SVH
`define INTEGER_TO_ASCII_CONVERTER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ITOA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa package
// types, constants and the digit to character mapping of the converter
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int VALUE_W   = 64;
   localparam int BASE_W    = 5;
   localparam int WIDTH_W   = 7;
   localparam int DIGIT_W   = 4;
   localparam int CHAR_W    = 8;
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = VALUE_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [BASE_W-1:0]  RADIX_MIN = 5'd2;
   localparam logic [BASE_W-1:0]  RADIX_MAX = 5'd16;
   localparam logic [BASE_W-1:0]  RADIX_DEC = 5'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOAD,
      ST_SIGN,
      ST_PAD,
      ST_DIGIT
   } itoa_state_type;

   typedef struct packed {
      logic              start;
      logic [BASE_W-1:0] radix;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] digit,
                                                    logic upper);
      logic [CHAR_W-1:0] letter_base;
      letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (digit < DIGIT_TEN) begin
         return CHAR_ZERO + CHAR_W'(digit);
      end else begin
         return letter_base + CHAR_W'(digit - DIGIT_TEN);
      end
   endfunction

endpackage

FILE: rtl/itoa_ram.sv
// ----------------------------------------------------------------------------
// itoa ram
// generic single write port, single read port memory with registered read
// ----------------------------------------------------------------------------
module itoa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/itoa_divider.sv
// ----------------------------------------------------------------------------
// itoa divider
// radix divider, four quotient bits per cycle, 64-bit dividend
// ----------------------------------------------------------------------------
`include "integer_to_ascii_converter_macros.svh"

module itoa_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  itoa_pkg::div_cmd_type               div_cmd,
   input  logic [itoa_pkg::VALUE_W-1:0]        div_dividend,
   output itoa_pkg::div_status_type            div_status,
   output logic [itoa_pkg::VALUE_W-1:0]        div_quotient
);
   import itoa_pkg::*;

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   quo_ff, quo_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [BASE_W-1:0]    radix_ff, radix_in;

   // restoring division, one radix compare per quotient bit
   always_comb begin
      logic [VALUE_W-1:0] q;
      logic [DIGIT_W-1:0] r;
      logic [BASE_W-1:0]  t;
      q = quo_ff;
      r = rem_ff;
      t = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         t = {r, q[VALUE_W-1]};
         q = {q[VALUE_W-2:0], 1'b0};
         if (t >= radix_ff) begin
            t    = t - radix_ff;
            q[0] = 1'b1;
         end
         r = t[DIGIT_W-1:0];
      end

      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      radix_in  = radix_ff;
      if (div_cmd.start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         quo_in    = div_dividend;
         rem_in    = '0;
         radix_in  = div_cmd.radix;
      end else if (active_ff) begin
         quo_in = q;
         rem_in = r;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign div_status.done      = done_ff;
   assign div_status.remainder = rem_ff;
   assign div_quotient         = quo_ff;

   `ITOA_ASSERT_NEXT(a_start_activates, clock, reset, div_cmd.start, active_ff, "divider did not start")
   `ITOA_ASSERT_NOW(a_rem_below_radix, clock, reset, active_ff || done_ff, {1'b0, rem_ff} < radix_ff, "remainder not below radix")
   `ITOA_ASSERT_NOW(a_done_not_active, clock, reset, done_ff, !active_ff, "done while still dividing")

endmodule

FILE: rtl/integer_to_ascii_converter.sv
// ----------------------------------------------------------------------------
// integer to ascii converter
// formats a 64-bit value as padded ascii digits, one character per cycle
// ----------------------------------------------------------------------------
// a transfer is taken when start is high and busy is low; the req_ ports are
// sampled at that edge. busy stays high until the last character has gone.
// characters come out on rsp_char_code with rsp_valid high for one cycle
// each: an optional '-', the pad characters, then the digits most
// significant first; rsp_last marks the final one. the receiver cannot
// stall, so the run is emitted on consecutive cycles without gaps.
// digits are produced by one shared radix divider that retires four
// quotient bits a cycle; each digit is the remainder of a full 64-bit
// division, and the divider restarts on the quotient for every further
// digit. the run of characters follows the last division at one cycle
// per character, and the next transfer can be taken the cycle after the
// last character.
// synchronous reset returns the block to idle and drops any run in flight.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_converter_macros.svh"

module integer_to_ascii_converter #(
   parameter int MAX_DIGITS = 64,
   parameter int MAX_WIDTH  = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [itoa_pkg::VALUE_W-1:0]   req_value,
   input  logic                           req_is_signed,
   input  logic [itoa_pkg::BASE_W-1:0]    req_base,
   input  logic [itoa_pkg::WIDTH_W-1:0]   req_width,
   input  logic                           req_zero_pad,
   input  logic                           req_upper_case,
   output logic                           rsp_valid,
   output logic [itoa_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic                           rsp_last
);
   import itoa_pkg::*;

   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

   itoa_state_type       state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic                 zero_pad_ff, zero_pad_in;
   logic                 upper_ff, upper_in;
   logic [BASE_W-1:0]    radix_ff, radix_in;
   logic [WIDTH_W-1:0]   w_ff, w_in;
   logic [WIDTH_W-1:0]   pad_ff, pad_in;
   logic [CNT_W-1:0]     nd_ff, nd_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;

   logic                 accept;
   logic                 more_digits;
   logic                 neg_req;
   logic [BASE_W-1:0]    radix_req;
   logic [WIDTH_W-1:0]   w_req;
   logic [VALUE_W-1:0]   mag_req;
   logic [WIDTH_W-1:0]   nd_ext;

   div_cmd_type          div_cmd;
   div_status_type       div_status;
   logic [VALUE_W-1:0]   div_dividend;
   logic [VALUE_W-1:0]   div_quotient;

   logic                 ram_wr_en;
   logic [DIGIT_W-1:0]   ram_rd_data;

   itoa_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_cmd      (div_cmd),
      .div_dividend (div_dividend),
      .div_status   (div_status),
      .div_quotient (div_quotient)
   );

   itoa_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (nd_ff[ADDR_W-1:0]),
      .wr_data (div_status.remainder),
      .rd_addr (ptr_in),
      .rd_data (ram_rd_data)
   );

   assign accept = start && (state_ff == ST_IDLE);

   // decode of the request
   always_comb begin
      neg_req   = req_is_signed && req_value[VALUE_W-1];
      mag_req   = neg_req ? (VALUE_W'(0) - req_value) : req_value;
      radix_req = req_base;
      if (req_is_signed || (req_base < RADIX_MIN) || (req_base > RADIX_MAX)) begin
         radix_req = RADIX_DEC;
      end
      w_req = req_width;
      if (req_width > WIDTH_W'(MAX_WIDTH)) begin
         w_req = WIDTH_W'(MAX_WIDTH);
      end
      if (neg_req && (w_req != '0)) begin
         w_req = w_req - WIDTH_W'(1);
      end
   end

   assign more_digits = (div_quotient != '0) && (nd_ff < CNT_W'(MAX_DIGITS - 1));
   assign nd_ext      = WIDTH_W'(nd_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done && !more_digits) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (neg_ff) begin
               state_in = ST_SIGN;
            end else if (w_ff > nd_ext) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            state_in = (pad_ff != '0) ? ST_PAD : ST_DIGIT;
         end
         ST_PAD: begin
            if (pad_ff == WIDTH_W'(1)) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (ptr_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and divider control
   always_comb begin
      neg_in       = neg_ff;
      zero_pad_in  = zero_pad_ff;
      upper_in     = upper_ff;
      radix_in     = radix_ff;
      w_in         = w_ff;
      pad_in       = pad_ff;
      nd_in        = nd_ff;
      ptr_in       = ptr_ff;
      ram_wr_en    = 1'b0;
      div_cmd      = '{start: 1'b0, radix: radix_ff};
      div_dividend = div_quotient;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in        = neg_req;
               zero_pad_in   = req_zero_pad;
               upper_in      = req_upper_case;
               radix_in      = radix_req;
               w_in          = w_req;
               nd_in         = '0;
               div_cmd.start = 1'b1;
               div_cmd.radix = radix_req;
               div_dividend  = mag_req;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               ram_wr_en     = 1'b1;
               nd_in         = nd_ff + CNT_W'(1);
               div_cmd.start = more_digits;
            end
         end
         ST_LOAD: begin
            // final digit was written last cycle, so its read starts here
            ptr_in = ADDR_W'(nd_ff - CNT_W'(1));
            pad_in = (w_ff > nd_ext) ? (w_ff - nd_ext) : '0;
         end
         ST_PAD: begin
            pad_in = pad_ff - WIDTH_W'(1);
         end
         ST_DIGIT: begin
            if (ptr_ff != '0) begin
               ptr_in = ptr_ff - ADDR_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // result outputs
   always_comb begin
      rsp_valid     = 1'b0;
      rsp_char_code = CHAR_SPACE;
      rsp_last      = 1'b0;
      busy          = (state_ff != ST_IDLE);
      case (state_ff)
         ST_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_char_code = CHAR_MINUS;
         end
         ST_PAD: begin
            rsp_valid     = 1'b1;
            rsp_char_code = zero_pad_ff ? CHAR_ZERO : CHAR_SPACE;
         end
         ST_DIGIT: begin
            rsp_valid     = 1'b1;
            rsp_char_code = digit_char(ram_rd_data, upper_ff);
            rsp_last      = (ptr_ff == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      zero_pad_ff <= zero_pad_in;
      upper_ff    <= upper_in;
      radix_ff    <= radix_in;
      w_ff        <= w_in;
      pad_ff      <= pad_in;
      nd_ff       <= nd_in;
      ptr_ff      <= ptr_in;
   end

   `ITOA_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_valid && rsp_last, !busy, "block still busy after last character")
   `ITOA_ASSERT_NEXT(a_run_unbroken, clock, reset, rsp_valid && !rsp_last, rsp_valid, "gap inside a character run")
   `ITOA_ASSERT_NOW(a_done_in_divide, clock, reset, div_status.done, state_ff == ST_DIVIDE, "divider finished outside digit extraction")
   `ITOA_ASSERT_NEXT(a_accept_quiet, clock, reset, start && !busy, busy && !rsp_valid, "transfer not followed by digit extraction")

endmodule
